// ----- rtl/core/nfr_pkg.sv -----
// shared types and constants of the nibble frame receiver
`timescale 1ns / 1ps
`default_nettype none
package nfr_pkg;

   // field widths of the stream payloads
   localparam int CHANNEL_W = 2;
   localparam int CHAR_W    = 8;
   localparam int INDEX_W   = 6;
   localparam int STATUS_W  = 2;
   localparam int LENGTH_W  = 7;
   localparam int DATA_W    = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // framing characters
   localparam logic [CHAR_W-1:0] CHAR_STX         = 8'h02;
   localparam logic [CHAR_W-1:0] CHAR_ETX         = 8'h03;
   localparam logic [CHAR_W-1:0] NIBBLE_MASK      = 8'h0f;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_FIRST = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_UPPER_END   = 8'h5a;  // 'Z', excluded
   localparam logic [CHAR_W-1:0] CHAR_LOWER_FIRST = 8'h61;  // 'a'
   localparam logic [CHAR_W-1:0] CHAR_LOWER_END   = 8'h7a;  // 'z', excluded

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      MODE_CHAR = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_STX,
      KIND_ETX,
      KIND_UPPER,
      KIND_LOWER,
      KIND_OTHER,
      KIND_READ
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE,
      STATUS_ACCEPT,
      STATUS_MISMATCH,
      STATUS_OVERFLOW
   } status_type;

   typedef struct packed {
      kind_type               kind;
      logic [CHANNEL_W-1:0]   channel;
      logic [3:0]             nibble;
      logic [INDEX_W-1:0]     read_index;
   } cmd_type;

   typedef struct packed {
      status_type             status;
      logic                   frame_ready;
      logic [LENGTH_W-1:0]    frame_length;
      logic                   data_sel;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/core/nibble_frame_receiver.sv -----
// top level of the multi-channel stx/etx nibble frame receiver
//
// req_* carries one item per transfer: a received character (req_tuser = 0)
// that advances the framing state of its channel, or a read (req_tuser = 1)
// of one stored payload byte of a checked frame. rsp_* returns exactly one
// result per item, in order: status, frame ready flag, frame length and read
// byte. Items for a channel at or above CHANNELS get an all-zero result.
// Throughput is one item per cycle while rsp_tready does not stall; the
// per-channel state update and the frame store port each handle one item a
// cycle. When the result side is free, an accepted item is first written to
// the two-entry command queue, then loads the result register (frame store
// read), which raises rsp_tvalid. A stall on rsp_tready holds the result
// register; the queue absorbs two more items before req_tready drops. Reset
// empties the queue and result register and clears every channel; the frame
// store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module nibble_frame_receiver #(
   parameter int FRAME_BYTES = 64,
   parameter int CHANNELS    = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // channel[1:0], rx_char[9:2], read_index[15:10]
   input  wire logic [nfr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode[0]
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status[1:0], frame_ready[2], frame_length[9:3], read_data[17:10], zero fill
   output logic [nfr_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import nfr_pkg::*;

   cmd_type           front_cmd;
   cmd_type           queue_cmd;
   logic              queue_valid;
   logic              back_ready;
   result_type        res;
   logic [DATA_W-1:0] res_data;

   nfr_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .mode       (req_tuser),
      .channel    (req_tdata[1:0]),
      .rx_char    (req_tdata[9:2]),
      .read_index (req_tdata[15:10]),
      .cmd        (front_cmd)
   );

   nfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_cmd   (queue_cmd)
   );

   nfr_back #(
      .FRAME_BYTES (FRAME_BYTES),
      .CHANNELS    (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (back_ready),
      .cmd       (queue_cmd),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res),
      .res_data  (res_data)
   );

   assign rsp_tdata = {6'b0, res_data, res.frame_length, res.frame_ready, res.status};

endmodule
`default_nettype wire

// ----- rtl/core/nfr_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module nfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/nfr_front.sv -----
// front end: classifies incoming items into commands for the back end
`timescale 1ns / 1ps
`default_nettype none
module nfr_front #(
   parameter int CHANNELS = 4
) (
   input  wire logic                          mode,
   input  wire logic [nfr_pkg::CHANNEL_W-1:0] channel,
   input  wire logic [nfr_pkg::CHAR_W-1:0]    rx_char,
   input  wire logic [nfr_pkg::INDEX_W-1:0]   read_index,
   output nfr_pkg::cmd_type                   cmd
);
   import nfr_pkg::*;

   logic [CHAR_W-1:0] upper_off;
   logic [CHAR_W-1:0] lower_off;

   assign upper_off = (rx_char - CHAR_UPPER_FIRST) & NIBBLE_MASK;
   assign lower_off = (rx_char - CHAR_LOWER_FIRST) & NIBBLE_MASK;

   always_comb begin
      cmd.channel    = channel;
      cmd.read_index = read_index;
      cmd.nibble     = 4'h0;
      if (32'(channel) >= CHANNELS) begin
         cmd.kind = KIND_NONE;
      end else if (mode == MODE_READ) begin
         cmd.kind = KIND_READ;
      end else if (rx_char == CHAR_STX) begin
         cmd.kind = KIND_STX;
      end else if (rx_char == CHAR_ETX) begin
         cmd.kind = KIND_ETX;
      end else if (rx_char >= CHAR_UPPER_FIRST && rx_char < CHAR_UPPER_END) begin
         cmd.kind   = KIND_UPPER;
         cmd.nibble = upper_off[3:0];
      end else if (rx_char >= CHAR_LOWER_FIRST && rx_char < CHAR_LOWER_END) begin
         cmd.kind   = KIND_LOWER;
         cmd.nibble = lower_off[3:0];
      end else begin
         cmd.kind = KIND_OTHER;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/nfr_queue.sv -----
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module nfr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire nfr_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output nfr_pkg::cmd_type      out_cmd
);
   import nfr_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW:0]        count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != (PW+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/nfr_back.sv -----
// back end: per-channel frame state, frame store and result register
`timescale 1ns / 1ps
`default_nettype none
module nfr_back #(
   parameter int FRAME_BYTES = 64,
   parameter int CHANNELS    = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       cmd_valid,
   output logic                            cmd_ready,
   input  wire nfr_pkg::cmd_type           cmd,
   output logic                            res_valid,
   input  wire logic                       res_ready,
   output nfr_pkg::result_type             res,
   output logic [nfr_pkg::DATA_W-1:0]      res_data
);
   import nfr_pkg::*;

   localparam int CW    = $clog2(FRAME_BYTES + 1);
   localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * FRAME_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CMPW  = (CW > INDEX_W) ? CW : INDEX_W;

   logic [CW-1:0]     count_ff [CHANNELS];
   logic [DATA_W-1:0] sum_ff   [CHANNELS];
   logic [DATA_W-1:0] cur_ff   [CHANNELS];
   logic              rdy_ff   [CHANNELS];

   result_type        res_ff, res_in;
   logic              res_valid_ff;

   logic [CIW-1:0]    cidx;
   logic [CW-1:0]     cnt, cnt_n;
   logic [DATA_W-1:0] sum, sum_n, cur, cur_n;
   logic              rdy, rdy_n;
   status_type        status;
   logic              fire, upd;
   logic              wr_en, rd_en;
   logic [AW-1:0]     base, wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign cmd_ready = !res_valid_ff || res_ready;
   assign fire      = cmd_valid && cmd_ready;
   assign upd       = fire && cmd.kind != KIND_NONE;

   assign cidx = CIW'(cmd.channel);
   assign cnt  = count_ff[cidx];
   assign sum  = sum_ff[cidx];
   assign cur  = cur_ff[cidx];
   assign rdy  = rdy_ff[cidx];
   assign base = AW'(cidx * FRAME_BYTES);

   always_comb begin
      cnt_n  = cnt;
      sum_n  = sum;
      cur_n  = cur;
      rdy_n  = rdy;
      status = STATUS_NONE;
      wr_en  = 1'b0;
      rd_en  = 1'b0;
      case (cmd.kind)
         KIND_STX: begin
            cnt_n = '0;
            sum_n = '0;
            cur_n = '0;
            rdy_n = 1'b0;
         end
         KIND_ETX: begin
            if (cnt != '0) begin
               if (cur == sum) begin
                  // checksum byte leaves the payload
                  cnt_n  = cnt - 1'b1;
                  rdy_n  = 1'b1;
                  status = STATUS_ACCEPT;
               end else begin
                  cnt_n  = '0;
                  sum_n  = '0;
                  cur_n  = '0;
                  rdy_n  = 1'b0;
                  status = STATUS_MISMATCH;
               end
            end
         end
         KIND_UPPER, KIND_LOWER, KIND_OTHER: begin
            if (cnt == CW'(FRAME_BYTES)) begin
               cnt_n  = '0;
               sum_n  = '0;
               cur_n  = '0;
               rdy_n  = 1'b0;
               status = STATUS_OVERFLOW;
            end else if (cmd.kind == KIND_UPPER) begin
               // fold the finished byte and its 1-based position into the sum
               if (cnt != '0) begin
                  sum_n = sum + cur + DATA_W'(cnt);
               end
               cur_n = {cmd.nibble, 4'h0};
            end else if (cmd.kind == KIND_LOWER) begin
               cur_n = cur | {4'h0, cmd.nibble};
               cnt_n = cnt + 1'b1;
               wr_en = upd;
            end
         end
         KIND_READ: begin
            rd_en = fire && rdy && (CMPW'(cmd.read_index) < CMPW'(cnt));
         end
         default: begin
         end
      endcase
   end

   assign wr_addr = base + AW'(cnt);
   assign rd_addr = base + AW'(cmd.read_index);

   always_comb begin
      res_in              = '0;
      if (cmd.kind != KIND_NONE) begin
         res_in.status       = status;
         res_in.frame_ready  = rdy_n;
         res_in.frame_length = rdy_n ? LENGTH_W'(cnt_n) : '0;
         res_in.data_sel     = rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            count_ff[i] <= '0;
            sum_ff[i]   <= '0;
            cur_ff[i]   <= '0;
            rdy_ff[i]   <= 1'b0;
         end
      end else if (upd) begin
         count_ff[cidx] <= cnt_n;
         sum_ff[cidx]   <= sum_n;
         cur_ff[cidx]   <= cur_n;
         rdy_ff[cidx]   <= rdy_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (fire) begin
         res_valid_ff <= 1'b1;
      end else if (res_ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

   // read data holds while the result stalls since no new read is issued
   nfr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cur_n),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_valid = res_valid_ff;
   assign res       = res_ff;
   assign res_data  = res_ff.data_sel ? rd_data : '0;

endmodule
`default_nettype wire

// ----- tb/nibble_frame_receiver_tb.sv -----
// self-checking testbench of the nibble frame receiver: directed frames, then random interleaved traffic
`timescale 1ns / 1ps
module nibble_frame_receiver_tb;
   import nfr_pkg::*;

   localparam int FRAME_BYTES = 64;
   localparam int CHANNELS    = 4;
   localparam int RANDOM_ITEMS = 1400;

   typedef struct {
      mode_type             mode;
      logic [CHANNEL_W-1:0] chan;
      logic [CHAR_W-1:0]    chr;
      logic [INDEX_W-1:0]   idx;
   } req_item_t;

   // per-channel deframer state and the queue of replies it predicts
   class frame_scoreboard;
      typedef struct {
         status_type          status;
         logic                ready;
         logic [LENGTH_W-1:0] length;
         logic [DATA_W-1:0]   data;
      } reply_t;

      reply_t              expected_replies[$];
      logic [DATA_W-1:0]   store [CHANNELS][FRAME_BYTES];
      logic [LENGTH_W-1:0] count [CHANNELS];
      logic [7:0]          csum [CHANNELS];
      logic [7:0]          partial [CHANNELS];
      logic                ready [CHANNELS];
      int failures;
      int n_items, n_accept, n_mismatch, n_overflow, n_reads;

      function new();
         for (int c = 0; c < CHANNELS; c++) begin
            count[c] = '0;
            csum[c] = '0;
            partial[c] = '0;
            ready[c] = 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++) store[c][i] = '0;
         end
         failures = 0;
         n_items = 0;
         n_accept = 0;
         n_mismatch = 0;
         n_overflow = 0;
         n_reads = 0;
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) $display("mismatch: %s", what);
      endfunction

      function int waiting();
         return expected_replies.size();
      endfunction

      function void note_request(logic mode_bit, logic [REQ_DATA_W-1:0] tdata);
         logic [CHANNEL_W-1:0] c;
         logic [CHAR_W-1:0]    chr;
         logic [INDEX_W-1:0]   idx;
         logic [7:0]           nib;
         reply_t               want;
         c = tdata[1:0];
         chr = tdata[9:2];
         idx = tdata[15:10];
         want.status = STATUS_NONE;
         want.data = '0;
         n_items++;
         if (mode_type'(mode_bit) == MODE_READ) begin
            n_reads++;
            if (ready[c] && idx < count[c]) want.data = store[c][idx];
         end else if (chr == CHAR_STX) begin
            count[c] = '0;
            csum[c] = '0;
            partial[c] = '0;
            ready[c] = 1'b0;
         end else if (chr == CHAR_ETX) begin
            if (count[c] != 0) begin
               if (partial[c] == csum[c]) begin
                  count[c] = count[c] - 1'b1;
                  ready[c] = 1'b1;
                  want.status = STATUS_ACCEPT;
               end else begin
                  count[c] = '0;
                  csum[c] = '0;
                  partial[c] = '0;
                  ready[c] = 1'b0;
                  want.status = STATUS_MISMATCH;
               end
            end
         end else if (count[c] >= FRAME_BYTES) begin
            // any further character on a full store drops the frame
            count[c] = '0;
            csum[c] = '0;
            partial[c] = '0;
            ready[c] = 1'b0;
            want.status = STATUS_OVERFLOW;
         end else if (chr >= CHAR_UPPER_FIRST && chr < CHAR_UPPER_END) begin
            if (count[c] != 0) csum[c] = csum[c] + partial[c] + {1'b0, count[c]};
            nib = chr - CHAR_UPPER_FIRST;
            partial[c] = {nib[3:0], 4'h0};
         end else if (chr >= CHAR_LOWER_FIRST && chr < CHAR_LOWER_END) begin
            nib = chr - CHAR_LOWER_FIRST;
            partial[c] = partial[c] | (nib & NIBBLE_MASK);
            store[c][count[c][INDEX_W-1:0]] = partial[c];
            count[c] = count[c] + 1'b1;
         end
         case (want.status)
            STATUS_ACCEPT:   n_accept++;
            STATUS_MISMATCH: n_mismatch++;
            STATUS_OVERFLOW: n_overflow++;
            default: ;
         endcase
         want.ready = ready[c];
         want.length = ready[c] ? count[c] : '0;
         expected_replies.push_back(want);
      endfunction

      function void check_reply(logic [RSP_DATA_W-1:0] tdata);
         reply_t want;
         if (expected_replies.size() == 0) begin
            flag($sformatf("result %h with nothing expected", tdata));
            return;
         end
         want = expected_replies.pop_front();
         if (tdata[1:0] !== want.status || tdata[2] !== want.ready ||
             tdata[9:3] !== want.length || tdata[17:10] !== want.data ||
             tdata[23:18] !== '0)
            flag($sformatf({"expected status %0d ready %0b length %0d data %h, ",
                            "got status %0d ready %0b length %0d data %h fill %h"},
                           want.status, want.ready, want.length, want.data,
                           tdata[1:0], tdata[2], tdata[9:3], tdata[17:10], tdata[23:18]));
      endfunction

      function void close();
         while (expected_replies.size() != 0) begin
            void'(expected_replies.pop_front());
            flag("expected result never arrived");
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   frame_scoreboard sb;
   req_item_t       script [CHANNELS][$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   nibble_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", sb.waiting());
      $display("nibble_frame_receiver_tb NOT OK");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_reply(rsp_tdata);
   end

   task automatic send_item(req_item_t it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tdata <= {it.idx, it.chr, it.chan};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_char(int c, logic [CHAR_W-1:0] chr);
      req_item_t it;
      it = '{MODE_CHAR, c[CHANNEL_W-1:0], chr, INDEX_W'($urandom_range(63))};
      send_item(it);
   endtask

   task automatic send_read(int c, logic [INDEX_W-1:0] idx);
      req_item_t it;
      it = '{MODE_READ, c[CHANNEL_W-1:0], CHAR_W'($urandom_range(255)), idx};
      send_item(it);
   endtask

   // nibbles up to 8 have a second encoding sixteen letters higher
   function automatic logic [CHAR_W-1:0] letter(logic [CHAR_W-1:0] first, logic [3:0] nib);
      if (nib <= 4'd8 && $urandom_range(1) == 1) return first + 8'd16 + nib;
      return first + nib;
   endfunction

   function automatic void queue_char(int c, logic [CHAR_W-1:0] chr);
      req_item_t it;
      it = '{MODE_CHAR, c[CHANNEL_W-1:0], chr, INDEX_W'($urandom_range(63))};
      script[c].push_back(it);
   endfunction

   function automatic void queue_read(int c, logic [INDEX_W-1:0] idx);
      req_item_t it;
      it = '{MODE_READ, c[CHANNEL_W-1:0], CHAR_W'($urandom_range(255)), idx};
      script[c].push_back(it);
   endfunction

   function automatic void queue_byte(int c, logic [7:0] b);
      logic [CHAR_W-1:0] junk;
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0: junk = CHAR_UPPER_END;
            1: junk = CHAR_LOWER_END;
            2: junk = 8'h80 | CHAR_W'($urandom_range(127));
            default: junk = CHAR_W'($urandom_range(8'h40, 8'h04));
         endcase
         queue_char(c, junk);
      end
      queue_char(c, letter(CHAR_UPPER_FIRST, b[7:4]));
      queue_char(c, letter(CHAR_LOWER_FIRST, b[3:0]));
   endfunction

   // one random sequence for a channel: good frame, bad checksum, overflow or noise
   function automatic void plan_sequence(int c);
      int        kind;
      int        n;
      logic [7:0] sum;
      logic [7:0] b;
      req_item_t it;
      kind = $urandom_range(99);
      if (kind >= 87) begin
         repeat ($urandom_range(6, 1)) begin
            it.mode = mode_type'(1'($urandom_range(1)));
            it.chan = c[CHANNEL_W-1:0];
            it.chr = CHAR_W'($urandom_range(255));
            it.idx = INDEX_W'($urandom_range(63));
            script[c].push_back(it);
         end
         return;
      end
      queue_char(c, CHAR_STX);
      if (kind >= 77) begin
         repeat (FRAME_BYTES) queue_byte(c, 8'($urandom_range(255)));
         queue_char(c, ($urandom_range(1) == 1) ? letter(CHAR_LOWER_FIRST, 4'($urandom_range(15)))
                                                : 8'h80 | CHAR_W'($urandom_range(127)));
         queue_read(c, INDEX_W'($urandom_range(63)));
         return;
      end
      n = ($urandom_range(19) == 0) ? FRAME_BYTES - 1 : $urandom_range(12);
      sum = '0;
      for (int i = 1; i <= n; i++) begin
         b = 8'($urandom_range(255));
         sum = sum + b + 8'(i);
         queue_byte(c, b);
      end
      if (kind >= 62) sum = sum + 8'($urandom_range(255, 1));
      queue_byte(c, sum);
      // some frames are cut off and dropped by the next start character
      if ($urandom_range(11) == 0) return;
      queue_char(c, CHAR_ETX);
      repeat ($urandom_range(4))
         queue_read(c, INDEX_W'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                         : $urandom_range(n + 1)));
      if (kind < 62 && $urandom_range(5) == 0) begin
         queue_char(c, CHAR_ETX);
         queue_read(c, INDEX_W'($urandom_range(n)));
      end
      if (kind < 62 && n < 40 && $urandom_range(7) == 0) begin
         queue_byte(c, 8'($urandom_range(255)));
         queue_read(c, INDEX_W'(n));
      end
   endfunction

   task automatic run_random(int target);
      int        counted;
      int        c;
      req_item_t it;
      counted = 0;
      while (counted < target) begin
         c = $urandom_range(CHANNELS - 1);
         if (script[c].size() == 0) plan_sequence(c);
         it = script[c].pop_front();
         send_item(it);
         if (it.mode == MODE_READ || it.chr == CHAR_STX || it.chr == CHAR_ETX ||
             (it.chr >= CHAR_UPPER_FIRST && it.chr < CHAR_UPPER_END) ||
             (it.chr >= CHAR_LOWER_FIRST && it.chr < CHAR_LOWER_END))
            counted++;
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty channel, framing extremes, recheck, append, bad checksum
      send_read(0, 6'd0);
      send_char(0, CHAR_ETX);
      send_char(0, 8'hff);
      send_char(1, CHAR_STX);
      send_char(1, "Y");               // high nibble 8
      send_char(1, CHAR_UPPER_END);
      send_char(1, "a");               // byte 0x80
      send_char(1, "A");
      send_char(1, CHAR_LOWER_END);
      send_char(1, "y");               // byte 0x08
      send_char(1, "I");
      send_char(1, "l");               // checksum 0x8b
      send_char(1, CHAR_ETX);
      send_read(1, 6'd0);
      send_read(1, 6'd1);
      send_read(1, 6'd2);
      send_read(1, 6'd63);
      send_char(1, CHAR_ETX);          // same checksum again, length shrinks
      send_char(1, "B");
      send_char(1, "b");               // appended after acceptance
      send_read(1, 6'd1);
      send_char(3, CHAR_STX);
      send_char(3, "B");
      send_char(3, "c");
      send_char(3, CHAR_ETX);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
               hold_request = 400;
            end
            1: begin
               send_idle_pct = 79;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 79;
            end
            default: begin
               send_idle_pct = 31;
               rsp_stall_pct = 31;
            end
         endcase
         run_random(RANDOM_ITEMS / 4);
      end
      req_tvalid <= 1'b0;
      rsp_stall_pct = 0;

      while (sb.waiting() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.close();
      $display("covered %0d transfers (%0d reads) on %0d channels under four idle patterns",
               sb.n_items, sb.n_reads, CHANNELS);
      $display("frames accepted %0d, checksum mismatches %0d, overflows %0d, failures %0d",
               sb.n_accept, sb.n_mismatch, sb.n_overflow, sb.failures);
      if (sb.failures == 0) begin
         $display("nibble_frame_receiver_tb OK");
      end else begin
         $display("nibble_frame_receiver_tb NOT OK");
      end
      $finish;
   end
endmodule

// ----- nibble_frame_receiver.f -----
rtl/core/nfr_pkg.sv
rtl/core/nfr_ram.sv
rtl/core/nfr_front.sv
rtl/core/nfr_queue.sv
rtl/core/nfr_back.sv
rtl/core/nibble_frame_receiver.sv
tb/nibble_frame_receiver_tb.sv
